>>> hw/rtl/ztstk_pkg.sv
// ----------------------------------------------------------------------------
// ztstk_pkg: shared definitions for the z-ordered tile stack
// Command and status codes, port widths and parameter defaults.
// ----------------------------------------------------------------------------
package ztstk_pkg;

   // Fixed widths of the request and response fields.
   localparam int CMD_BITS       = 3;
   localparam int COORD_PORT_BITS = 12;
   localparam int COLOUR_BITS    = 16;
   localparam int STATUS_BITS    = 2;
   localparam int RSP_NUM_BITS   = 7;

   // Parameter defaults.
   localparam int DEFAULT_CAPACITY   = 64;
   localparam int DEFAULT_COORD_BITS = 12;

   // Command codes.
   localparam logic [CMD_BITS-1:0] CMD_ADD        = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_HIT_TEST   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_RAISE      = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_LOWER      = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE     = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE_ALL = 3'd5;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

endpackage

>>> hw/rtl/z_ordered_tile_stack_core.sv
// ----------------------------------------------------------------------------
// z_ordered_tile_stack_core: ordered stack of rectangles with point hit test
// Holds up to CAPACITY tiles bottom first in a memory with one read and one
// write port, and runs add, hit test, raise, lower, remove and remove-all
// requests.
// ----------------------------------------------------------------------------
// The block works on one request at a time and holds req_stall high until the
// response has been taken. Every stack walk goes through the single tile
// memory, one entry per cycle through a registered read port, and the cover
// test is one shared compare unit on the read data. An add or an unused
// command code goes straight to the response; a hit test is a top-down scan
// for the hit; raise and remove are that scan followed by a shift of the
// entries above the hit; lower is the scan above the hit and a shift of the
// entries below it, which together cover the stack once; and remove-all is one
// bottom-up compaction pass. The memory needs no clearing after reset.
module z_ordered_tile_stack_core #(
   parameter int CAPACITY   = ztstk_pkg::DEFAULT_CAPACITY,
   parameter int COORD_BITS = ztstk_pkg::DEFAULT_COORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // Request channel.
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ztstk_pkg::CMD_BITS-1:0]          req_cmd,
   input  logic [ztstk_pkg::COORD_PORT_BITS-1:0]   req_point_x,
   input  logic [ztstk_pkg::COORD_PORT_BITS-1:0]   req_point_y,
   input  logic [ztstk_pkg::COORD_PORT_BITS-1:0]   req_tile_left,
   input  logic [ztstk_pkg::COORD_PORT_BITS-1:0]   req_tile_top,
   input  logic [ztstk_pkg::COORD_PORT_BITS-1:0]   req_tile_wide,
   input  logic [ztstk_pkg::COORD_PORT_BITS-1:0]   req_tile_tall,
   input  logic [ztstk_pkg::COLOUR_BITS-1:0]       req_tile_colour,
   // Response channel.
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [ztstk_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic signed [ztstk_pkg::RSP_NUM_BITS-1:0] rsp_hit_index,
   output logic [ztstk_pkg::RSP_NUM_BITS-1:0]      rsp_tile_count,
   output logic [ztstk_pkg::RSP_NUM_BITS-1:0]      rsp_removed_count
);
   import ztstk_pkg::*;

   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int ENTRY_BITS = 4 * COORD_BITS + COLOUR_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_SWEEP,
      ST_RESP
   } state_type;

   // Sequencer and datapath registers.
   state_type                state_ff, state_in;
   logic [CMD_BITS-1:0]      cmd_ff, cmd_in;
   logic [COORD_BITS-1:0]    px_ff, px_in;
   logic [COORD_BITS-1:0]    py_ff, py_in;
   logic [CNT_BITS-1:0]      held_ff, held_in;
   logic [CNT_BITS-1:0]      iss_ff, iss_in;
   logic                     dir_up_ff, dir_up_in;
   logic                     pend_ff, pend_in;
   logic [IDX_BITS-1:0]      pend_idx_ff, pend_idx_in;
   logic [CNT_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic                     found_ff, found_in;
   logic [IDX_BITS-1:0]      hit_idx_ff, hit_idx_in;
   logic [ENTRY_BITS-1:0]    moved_ff, moved_in;
   logic [CNT_BITS-1:0]      removed_ff, removed_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;

   // Tile memory and its ports.
   logic [ENTRY_BITS-1:0]    store_mem [CAPACITY];
   logic [ENTRY_BITS-1:0]    rd_data_ff;
   logic [IDX_BITS-1:0]      rd_addr;
   logic                     rd_en;
   logic                     wr_en;
   logic [IDX_BITS-1:0]      wr_addr;
   logic [ENTRY_BITS-1:0]    wr_data;

   // Issue control and cover test.
   logic                     can_issue;
   logic [CNT_BITS-1:0]      iss_dec;
   logic                     req_accept;
   logic                     cover_hit;
   logic [COORD_BITS-1:0]    ent_left, ent_top, ent_wide, ent_tall;
   logic [COORD_BITS:0]      ent_right, ent_bottom;
   logic [IDX_BITS+RSP_NUM_BITS-1:0] hit_wide;
   logic [CNT_BITS+RSP_NUM_BITS-1:0] held_wide;
   logic [CNT_BITS+RSP_NUM_BITS-1:0] removed_wide;

   // Handshake.
   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);

   // Read sequencing: ascending walks stop at the held count, descending at zero.
   assign iss_dec   = iss_ff - CNT_BITS'(1);
   assign can_issue = dir_up_ff ? (iss_ff != held_ff) : (iss_ff != '0);
   assign rd_addr   = dir_up_ff ? iss_ff[IDX_BITS-1:0] : iss_dec[IDX_BITS-1:0];
   assign rd_en     = can_issue && ((state_ff == ST_SCAN) || (state_ff == ST_SHIFT) ||
                                    (state_ff == ST_SWEEP));

   // Shared cover test on the entry just read: half-open, sums without wrap.
   assign ent_left   = rd_data_ff[COORD_BITS-1:0];
   assign ent_top    = rd_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign ent_wide   = rd_data_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign ent_tall   = rd_data_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign ent_right  = {1'b0, ent_left} + {1'b0, ent_wide};
   assign ent_bottom = {1'b0, ent_top} + {1'b0, ent_tall};
   assign cover_hit  = (px_ff >= ent_left) && ({1'b0, px_ff} < ent_right) &&
                       (py_ff >= ent_top)  && ({1'b0, py_ff} < ent_bottom);

   // Response fields, reported modulo 2^7.
   assign hit_wide          = {{RSP_NUM_BITS{1'b0}}, hit_idx_ff};
   assign held_wide         = {{RSP_NUM_BITS{1'b0}}, held_ff};
   assign removed_wide      = {{RSP_NUM_BITS{1'b0}}, removed_ff};
   assign rsp_status        = status_ff;
   assign rsp_hit_index     = found_ff ? hit_wide[RSP_NUM_BITS-1:0] : '1;
   assign rsp_tile_count    = held_wide[RSP_NUM_BITS-1:0];
   assign rsp_removed_count = removed_wide[RSP_NUM_BITS-1:0];

   // Next-state logic of the sequencer and the memory write port.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      held_in     = held_ff;
      iss_in      = iss_ff;
      dir_up_in   = dir_up_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      wr_ptr_in   = wr_ptr_ff;
      found_in    = found_ff;
      hit_idx_in  = hit_idx_ff;
      moved_in    = moved_ff;
      removed_in  = removed_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;

      // Advance the read walk in the scan, shift and sweep states; a state may override it.
      if (rd_en) begin
         pend_in     = 1'b1;
         pend_idx_in = rd_addr;
         iss_in      = dir_up_ff ? (iss_ff + CNT_BITS'(1)) : iss_dec;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_cmd;
               px_in      = req_point_x[COORD_BITS-1:0];
               py_in      = req_point_y[COORD_BITS-1:0];
               found_in   = 1'b0;
               removed_in = '0;
               status_in  = STATUS_DONE;
               case (req_cmd)
                  CMD_ADD: begin
                     if (held_ff == CNT_BITS'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = held_ff[IDX_BITS-1:0];
                        wr_data = {req_tile_colour,
                                   req_tile_tall[COORD_BITS-1:0],
                                   req_tile_wide[COORD_BITS-1:0],
                                   req_tile_top[COORD_BITS-1:0],
                                   req_tile_left[COORD_BITS-1:0]};
                        held_in = held_ff + CNT_BITS'(1);
                     end
                     state_in = ST_RESP;
                  end
                  CMD_HIT_TEST, CMD_RAISE, CMD_LOWER, CMD_REMOVE: begin
                     // Top-down scan for the topmost covering tile.
                     iss_in    = held_ff;
                     dir_up_in = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  CMD_REMOVE_ALL: begin
                     // Bottom-up compaction pass.
                     iss_in    = '0;
                     dir_up_in = 1'b1;
                     wr_ptr_in = '0;
                     state_in  = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (pend_ff && cover_hit) begin
               found_in   = 1'b1;
               hit_idx_in = pend_idx_ff;
               moved_in   = rd_data_ff;
               pend_in    = 1'b0;
               case (cmd_ff)
                  CMD_RAISE, CMD_REMOVE: begin
                     // Shift the entries above the hit down by one.
                     iss_in    = CNT_BITS'(pend_idx_ff) + CNT_BITS'(1);
                     dir_up_in = 1'b1;
                     state_in  = ST_SHIFT;
                  end
                  CMD_LOWER: begin
                     // Shift the entries below the hit up by one.
                     iss_in    = CNT_BITS'(pend_idx_ff);
                     dir_up_in = 1'b0;
                     state_in  = ST_SHIFT;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end else if (!can_issue && !pend_ff) begin
               status_in = STATUS_MISS;
               state_in  = ST_RESP;
            end
         end

         ST_SHIFT: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = dir_up_ff ? IDX_BITS'(pend_idx_ff - IDX_BITS'(1))
                                   : IDX_BITS'(pend_idx_ff + IDX_BITS'(1));
               wr_data = rd_data_ff;
            end else if (!can_issue) begin
               // Shift finished: place the moved tile or drop it.
               case (cmd_ff)
                  CMD_RAISE: begin
                     wr_en   = 1'b1;
                     wr_addr = iss_dec[IDX_BITS-1:0];
                     wr_data = moved_ff;
                  end
                  CMD_LOWER: begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = moved_ff;
                  end
                  CMD_REMOVE: begin
                     held_in    = held_ff - CNT_BITS'(1);
                     removed_in = CNT_BITS'(1);
                  end
                  default: begin
                     wr_en = 1'b0;
                  end
               endcase
               status_in = STATUS_DONE;
               state_in  = ST_RESP;
            end
         end

         ST_SWEEP: begin
            if (pend_ff) begin
               if (cover_hit) begin
                  removed_in = removed_ff + CNT_BITS'(1);
                  found_in   = 1'b1;
                  hit_idx_in = pend_idx_ff;
               end else begin
                  wr_en     = 1'b1;
                  wr_addr   = wr_ptr_ff[IDX_BITS-1:0];
                  wr_data   = rd_data_ff;
                  wr_ptr_in = wr_ptr_ff + CNT_BITS'(1);
               end
            end else if (!can_issue) begin
               held_in   = wr_ptr_ff;
               status_in = found_ff ? STATUS_DONE : STATUS_MISS;
               state_in  = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Tile memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Sequencer state and registered response fields.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         held_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
      cmd_ff      <= cmd_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      iss_ff      <= iss_in;
      dir_up_ff   <= dir_up_in;
      pend_idx_ff <= pend_idx_in;
      wr_ptr_ff   <= wr_ptr_in;
      found_ff    <= found_in;
      hit_idx_ff  <= hit_idx_in;
      moved_ff    <= moved_in;
      removed_ff  <= removed_in;
      status_ff   <= status_in;
   end

endmodule
